>>> rtl/core/vwcp_pkg.sv
// Package with widths, types and constants of the variable width code packer.
`timescale 1ns / 1ps

package vwcp_pkg;

  // Field widths of one input word and one output word
  localparam int unsigned CodeBits  = 16;
  localparam int unsigned WidthBits = 5;
  localparam int unsigned ByteBits  = 8;

  // Largest code width honored; wider requests saturate to it
  localparam int unsigned MaxCodeWidth = 16;
  localparam int unsigned CapWidth     = (MaxCodeWidth < CodeBits) ? MaxCodeWidth : CodeBits;
  localparam logic [WidthBits-1:0] WidthCap = WidthBits'(CapWidth);

  // Bit slot that the first bit of a fresh byte goes to
  localparam logic [2:0] TopBit = 3'd7;

  // Staging vector: partial byte plus the widest code fits in three bytes
  localparam int unsigned AccBits = 3 * ByteBits;

  typedef logic [CodeBits-1:0]  code_t;
  typedef logic [WidthBits-1:0] width_t;
  typedef logic [ByteBits-1:0]  byte_t;

endpackage

>>> rtl/core/variable_width_code_packer_unit.sv
// Top level of the MSB-first variable width code packer.
`timescale 1ns / 1ps

// Packs codes of 1 to 16 bits (wider widths saturate to 16, zero appends
// nothing) into bytes, first bit in bit 7. Each accepted word yields 0 to 3
// output bytes: every byte that fills up, then on flush the zero-padded
// partial byte (emitted even when it holds no bits). last_o marks the final
// byte caused by one input word. An input word is registered, packed
// combinationally into a three-byte result buffer, and the buffer drains one
// byte per cycle on the output port while out_ready_i is high. A word that
// fills no byte passes without taking the buffer; a word yielding bytes
// holds it until its last byte is taken, so the byte-wide output port sets
// the rate. The input register holds one word while the buffer drains; once
// it holds a word that yields bytes, in_ready_o follows out_ready_i
// combinationally on the last byte of the buffered word.
module variable_width_code_packer_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  vwcp_pkg::code_t  code_value_i,
  input  vwcp_pkg::width_t code_width_i,
  input  logic            flush_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output vwcp_pkg::byte_t  out_byte_o,
  output logic            last_o
);
  import vwcp_pkg::*;

  // Input register
  logic   in_vld_q;
  code_t  code_q;
  width_t width_q;
  logic   flush_q;

  // Packer state
  byte_t      partial_q, partial_d;
  logic [2:0] pos_q, pos_d;

  // Result buffer
  byte_t      res_q [3];
  logic [1:0] res_cnt_q, res_idx_q;

  // Pack logic signals
  width_t               w_sat;
  code_t                code_mask;
  logic [AccBits-1:0]   code_ext;
  logic [AccBits-1:0]   acc;
  logic [2:0]           n_bits;
  logic [4:0]           total;
  logic [1:0]           n_full;
  logic [2:0]           n_rem;
  logic [1:0]           pk_cnt;
  byte_t                pk_byte [3];
  byte_t                tail_byte;

  logic out_fire, res_done, res_free, move;

  // Pack the registered word against the partial byte
  always_comb begin
    w_sat     = (width_q > WidthCap) ? WidthCap : width_q;
    n_bits    = TopBit - pos_q;
    code_mask = code_q & (code_t'({CodeBits{1'b1}}) >> (WidthBits'(CodeBits) - w_sat));
    code_ext  = {code_mask, {(AccBits-CodeBits){1'b0}}} << (WidthBits'(CodeBits) - w_sat);
    acc       = {partial_q, {(AccBits-ByteBits){1'b0}}} | (code_ext >> n_bits);
    total     = 5'(n_bits) + 5'(w_sat);
    n_full    = total[4:3];
    n_rem     = total[2:0];
    pk_byte[0] = acc[3*ByteBits-1:2*ByteBits];
    pk_byte[1] = acc[2*ByteBits-1:ByteBits];
    pk_byte[2] = acc[ByteBits-1:0];
    case (n_full)
      2'd0:    tail_byte = pk_byte[0];
      2'd1:    tail_byte = pk_byte[1];
      2'd2:    tail_byte = pk_byte[2];
      default: tail_byte = pk_byte[2];
    endcase
    pk_cnt = n_full + 2'(flush_q);
    if (flush_q) begin
      partial_d = '0;
      pos_d     = TopBit;
    end else begin
      partial_d = tail_byte;
      pos_d     = TopBit - n_rem;
    end
  end

  // Handshake and buffer control
  assign out_valid_o = (res_cnt_q != 2'd0);
  assign last_o      = (res_idx_q == res_cnt_q - 2'd1);
  assign out_fire    = out_valid_o & out_ready_i;
  assign res_done    = out_fire & last_o;
  assign res_free    = !out_valid_o || res_done;
  assign move        = in_vld_q && (res_free || pk_cnt == 2'd0);
  assign in_ready_o  = !in_vld_q || move;

  always_comb begin
    case (res_idx_q)
      2'd0:    out_byte_o = res_q[0];
      2'd1:    out_byte_o = res_q[1];
      2'd2:    out_byte_o = res_q[2];
      default: out_byte_o = res_q[2];
    endcase
  end

  // Input word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      code_q  <= code_value_i;
      width_q <= code_width_i;
      flush_q <= flush_i;
    end
  end

  // Packer state and result buffer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      pos_q     <= TopBit;
      res_cnt_q <= 2'd0;
      res_idx_q <= 2'd0;
    end else begin
      if (move) begin
        partial_q <= partial_d;
        pos_q     <= pos_d;
      end
      if (move && pk_cnt != 2'd0) begin
        res_cnt_q <= pk_cnt;
        res_idx_q <= 2'd0;
      end else if (res_done) begin
        res_cnt_q <= 2'd0;
        res_idx_q <= 2'd0;
      end else if (out_fire) begin
        res_idx_q <= res_idx_q + 2'd1;
      end
    end
  end

  // Result bytes; flush byte lands right after the full bytes
  always_ff @(posedge clk_i) begin
    if (move && pk_cnt != 2'd0) begin
      res_q[0] <= pk_byte[0];
      res_q[1] <= pk_byte[1];
      res_q[2] <= pk_byte[2];
    end
  end

endmodule

>>> sim/variable_width_code_packer_unit_tb.sv
// Self-checking testbench for the variable width code packer unit.
`timescale 1ns / 1ps

module variable_width_code_packer_unit_tb;

  import vwcp_pkg::*;

  // One input word and one packed output byte
  typedef struct packed {
    code_t  code;
    width_t width;
    logic   flush;
  } code_word_t;

  typedef struct packed {
    byte_t data;
    logic  last;
  } packed_byte_t;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned HoldAt      = 40;    // results seen before the long hold
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned PauseAt     = 70;    // words sent before draining out
  localparam int unsigned DrainCycles = 20;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic       in_valid  = 1'b0;
  logic       in_ready;
  code_word_t cur_word  = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  byte_t      out_byte;
  logic       out_last;

  code_word_t   word_q[$];   // words waiting to be offered
  packed_byte_t byte_q[$];   // bytes the packer should emit, in stream order

  // Packer state as predicted
  byte_t    acc_byte = '0;
  logic [2:0] acc_pos = TopBit;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned tx_cnt      = 0;
  int unsigned rx_cnt      = 0;
  int unsigned hold_cnt    = 0;
  logic        hold_done   = 1'b0;
  logic        drain_hold  = 1'b0;
  int unsigned err_cnt     = 0;
  int unsigned cyc_cnt     = 0;

  variable_width_code_packer_unit u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .code_value_i (cur_word.code),
    .code_width_i (cur_word.width),
    .flush_i      (cur_word.flush),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .out_byte_o   (out_byte),
    .last_o       (out_last)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Append one code MSB first and queue the bytes it completes
  task automatic pack_code(input code_word_t w);
    byte_t       done[3];
    int unsigned n;
    int unsigned eff;
    n   = 0;
    eff = (w.width > WidthCap) ? CapWidth : int'(w.width);
    for (int k = eff; k > 0; k--) begin
      if (w.code[k-1]) acc_byte[acc_pos] = 1'b1;
      if (acc_pos == 3'd0) begin
        done[n]  = acc_byte;
        n++;
        acc_byte = '0;
        acc_pos  = TopBit;
      end else begin
        acc_pos = acc_pos - 3'd1;
      end
    end
    // flush emits the partial byte, empty or not
    if (w.flush) begin
      done[n]  = acc_byte;
      n++;
      acc_byte = '0;
      acc_pos  = TopBit;
    end
    for (int i = 0; i < n; i++) byte_q.push_back('{data: done[i], last: (i == n - 1)});
  endtask

  // Driver: offers pending words, predicts on each accepted word
  always @(posedge clk_i) begin : drv
    logic       nxt_valid;
    code_word_t nxt_word;
    nxt_valid = in_valid;
    nxt_word  = cur_word;
    if (in_valid && in_ready) begin
      pack_code(cur_word);
      tx_cnt++;
      if (tx_cnt == PauseAt) drain_hold = 1'b1;
      nxt_valid = 1'b0;
    end
    // sender pause: wait until every expected byte has come out
    if (drain_hold && byte_q.size() == 0) drain_hold = 1'b0;
    if (!nxt_valid && !drain_hold && rst_ni && word_q.size() > 0 &&
        $urandom_range(0, 99) >= tx_idle_pct) begin
      nxt_word  = word_q.pop_front();
      nxt_valid = 1'b1;
    end
    in_valid <= nxt_valid;
    cur_word <= nxt_word;
  end

  // Monitor: checks each accepted byte, drives ready with stalls
  always @(posedge clk_i) begin : mon
    packed_byte_t exp_b;
    logic         nxt_ready;
    if (out_valid && out_ready) begin
      rx_cnt++;
      if (byte_q.size() == 0) begin
        $error("unexpected byte: actual out_byte %02h last %0b", out_byte, out_last);
        err_cnt++;
      end else begin
        exp_b = byte_q.pop_front();
        if (out_byte !== exp_b.data) begin
          $error("out_byte mismatch: expected %02h, actual %02h", exp_b.data, out_byte);
          err_cnt++;
        end
        if (out_last !== exp_b.last) begin
          $error("last mismatch: expected %0b, actual %0b", exp_b.last, out_last);
          err_cnt++;
        end
      end
    end
    // one long hold-off so the block backs up into its input
    if (!hold_done && rx_cnt >= HoldAt) begin
      hold_done = 1'b1;
      hold_cnt  = HoldCycles;
    end
    if (!rst_ni) begin
      nxt_ready = 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      nxt_ready = 1'b0;
    end else begin
      nxt_ready = ($urandom_range(0, 99) >= rx_idle_pct);
    end
    out_ready <= nxt_ready;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt == CycleLimit) begin
      $display("variable_width_code_packer_unit_tb: errors");
      $finish;
    end
  end

  // Stimulus in three idling phases
  initial begin : stim
    code_word_t w;
    int unsigned sel;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int phase = 0; phase < 3; phase++) begin
      @(negedge clk_i);
      case (phase)
        0: begin
          tx_idle_pct = 10;
          rx_idle_pct = 82;
        end
        1: begin
          tx_idle_pct = 82;
          rx_idle_pct = 10;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase

      if (phase == 0) begin
        // zero width, alone and with an empty flush
        word_q.push_back('{code: 16'hFFFF, width: 5'd0,  flush: 1'b0});
        word_q.push_back('{code: 16'h0000, width: 5'd0,  flush: 1'b1});
        // full width, both extremes
        word_q.push_back('{code: 16'hFFFF, width: 5'd16, flush: 1'b0});
        word_q.push_back('{code: 16'h0000, width: 5'd16, flush: 1'b1});
        // byte-aligned code then flush of an empty byte
        word_q.push_back('{code: 16'hABCD, width: 5'd8,  flush: 1'b1});
        // upper bits beyond the width must be dropped
        word_q.push_back('{code: 16'hFFFF, width: 5'd3,  flush: 1'b0});
        word_q.push_back('{code: 16'h0005, width: 5'd5,  flush: 1'b1});
        word_q.push_back('{code: 16'h0001, width: 5'd1,  flush: 1'b0});
        // widths above range saturate
        word_q.push_back('{code: 16'h1234, width: 5'd31, flush: 1'b0});
        word_q.push_back('{code: 16'h8001, width: 5'd17, flush: 1'b1});
        word_q.push_back('{code: 16'h0000, width: 5'd1,  flush: 1'b1});
        word_q.push_back('{code: 16'hFFFF, width: 5'd15, flush: 1'b1});
        word_q.push_back('{code: 16'h5A5A, width: 5'd24, flush: 1'b0});
        word_q.push_back('{code: 16'h00FF, width: 5'd7,  flush: 1'b0});
        word_q.push_back('{code: 16'h7FFF, width: 5'd16, flush: 1'b1});
        // partial byte carried into a saturated wide code
        word_q.push_back('{code: 16'h0003, width: 5'd2,  flush: 1'b0});
        word_q.push_back('{code: 16'hC3A5, width: 5'd20, flush: 1'b1});
      end

      for (int i = 0; i < ((phase == 2) ? 35 : 40); i++) begin
        sel     = $urandom_range(0, 99);
        w.code  = code_t'($urandom_range(0, 65535));
        if (sel < 5)       w.width = '0;
        else if (sel < 12) w.width = width_t'($urandom_range(17, 31));
        else               w.width = width_t'($urandom_range(1, 16));
        w.flush = ($urandom_range(0, 99) < 15);
        word_q.push_back(w);
      end

      // wait until every word of this phase is accepted
      do @(negedge clk_i); while (word_q.size() > 0 || in_valid);
    end

    do @(negedge clk_i); while (byte_q.size() > 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("variable_width_code_packer_unit_tb: clean");
    end else begin
      $display("variable_width_code_packer_unit_tb: errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/vwcp_pkg.sv
rtl/core/variable_width_code_packer_unit.sv
sim/variable_width_code_packer_unit_tb.sv
